>>> src/swmax_pkg.sv
package swmax_pkg;

    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int CFG_WIDTH        = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd3;

endpackage

>>> src/swmax_cell.sv
module swmax_cell #(
    parameter int SAMPLE_WIDTH = swmax_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           advance,
    input  logic                           seq_start,
    input  logic signed [SAMPLE_WIDTH-1:0] new_value,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
    output logic signed [SAMPLE_WIDTH-1:0] max_next,
    output logic signed [SAMPLE_WIDTH-1:0] max_value
);

    logic signed [SAMPLE_WIDTH-1:0] max_reg;

    // keep the neighbor's running maximum only while it beats the new word and no sequence starts
    always_comb begin
        if (seq_start || (prev_value <= new_value)) begin
            max_next = new_value;
        end else begin
            max_next = prev_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            max_reg <= max_next;
        end
    end

    assign max_value = max_reg;

endmodule

>>> src/swmax_ctrl.sv
module swmax_ctrl #(
    parameter int MAX_WINDOW = swmax_pkg::DEF_MAX_WINDOW,
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1),
    localparam int IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [swmax_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                           advance,
    input  logic                           seq_start,
    output logic [IDX_W-1:0]               sel,
    output logic                           emit
);

    logic [swmax_pkg::CFG_WIDTH-1:0] window_size_reg;
    logic [CNT_W-1:0]                seen_reg;
    logic [CNT_W-1:0]                seen_next;
    logic [CNT_W-1:0]                eff_window;

    // clamp the programmed size into 1..MAX_WINDOW
    always_comb begin
        if (window_size_reg == '0) begin
            eff_window = CNT_W'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            eff_window = CNT_W'(MAX_WINDOW);
        end else begin
            eff_window = CNT_W'(window_size_reg);
        end
    end

    always_comb begin
        seen_next = seen_reg;
        if (advance) begin
            if (seq_start) begin
                seen_next = CNT_W'(1);
            end else if (seen_reg >= eff_window) begin
                seen_next = eff_window;
            end else begin
                seen_next = seen_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= swmax_pkg::WINDOW_RESET;
            seen_reg        <= '0;
        end else begin
            if (cfg_we) begin
                window_size_reg <= cfg_wdata;
            end
            seen_reg <= seen_next;
        end
    end

    assign emit = (seen_next >= eff_window);
    assign sel  = IDX_W'(eff_window - CNT_W'(1));

endmodule

>>> src/sliding_window_maximum_top.sv
// A result word is valid in the cycle after its sample word is accepted. Throughput:
// one sample word per cycle unless stalled; each cell does one compare per word
// against its neighbor, and the output register takes the cell picked by the window.
// Reset (aresetn low, synchronous): window size returns to 3, sample count and
// output valid clear; no clearing pass, the first word may be taken right after.
module sliding_window_maximum_top #(
    parameter int MAX_WINDOW   = swmax_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = swmax_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [swmax_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_sample_value,
    input  logic                            s_sequence_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  m_window_max
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic signed [SAMPLE_WIDTH-1:0] cell_next  [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
    logic                           advance;
    logic                           emit;
    logic [IDX_W-1:0]               sel;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_window_max_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign advance = s_valid && s_ready;

    swmax_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .seq_start (s_sequence_start),
        .sel       (sel),
        .emit      (emit)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            swmax_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .advance    (advance),
                .seq_start  (s_sequence_start),
                .new_value  (s_sample_value),
                .prev_value (s_sample_value),
                .max_next   (cell_next[i]),
                .max_value  (cell_value[i])
            );
        end else begin : g_body
            swmax_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .advance    (advance),
                .seq_start  (s_sequence_start),
                .new_value  (s_sample_value),
                .prev_value (cell_value[i-1]),
                .max_next   (cell_next[i]),
                .max_value  (cell_value[i])
            );
        end
    end

    always_comb begin
        if (advance) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_window_max_reg <= cell_next[sel];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_max = m_window_max_reg;

endmodule

>>> src/swmax_checker.sv
module swmax_checker #(
    parameter int SAMPLE_WIDTH = swmax_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_window_max
);

    logic accept;

    assign accept = s_valid && s_ready;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_max))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output stage empty");

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(accept))
        else $error("result word without an accepted sample word");

endmodule

bind sliding_window_maximum_top swmax_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swmax_checker (.*);
